>>> rtl/itab_pkg.sv
package itab_pkg;

	localparam int TABLE_DEPTH_DEF = 16;
	localparam logic [15:0] AGE_LIMIT_RESET = 16'd5000;

	localparam logic OP_LEARN = 1'b0;
	localparam logic OP_AGE   = 1'b1;

	typedef struct packed {
		logic        opcode;
		logic [31:0] unit_id;
		logic [31:0] now_time;
	} in_word_t;

	typedef struct packed {
		logic [3:0] slot_index;
		logic       was_hit;
		logic       full_miss;
		logic [4:0] live_count;
	} out_word_t;

	// per-cell controls for the current cycle
	typedef struct packed {
		logic compare;
		logic mark;
		logic shift;
		logic write_id;
		logic write_time;
	} cell_ctl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOK,
		ST_UPDATE,
		ST_MARK,
		ST_SHIFT
	} state_t;

endpackage

>>> rtl/itab_cell.sv
module itab_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  itab_pkg::cell_ctl_t ctl,
	input  logic [31:0]       unit_id,
	input  logic [31:0]       now_time,
	input  logic [15:0]       age_limit,
	input  logic              live,
	input  logic [31:0]       nxt_ident,
	input  logic [31:0]       nxt_seen,
	input  logic              nxt_drop,
	input  logic              shift_in,
	output logic [31:0]       ident,
	output logic [31:0]       seen,
	output logic              drop,
	output logic              match,
	output logic              shift_out
);

	logic [31:0] ident_q;
	logic [31:0] seen_q;
	logic        drop_q;
	logic        match_q;
	logic [31:0] age;
	logic        shift_here;
	logic        take_nxt;

	assign age        = now_time - seen_q;
	assign shift_here = shift_in | drop_q;
	assign take_nxt   = ctl.shift & shift_here;

	always_ff @(posedge clk) begin
		if (take_nxt) begin
			ident_q <= nxt_ident;
			seen_q  <= nxt_seen;
		end else begin
			if (ctl.write_id) begin
				ident_q <= unit_id;
			end
			if (ctl.write_time) begin
				seen_q <= now_time;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drop_q  <= 1'b0;
			match_q <= 1'b0;
		end else begin
			if (ctl.mark) begin
				drop_q <= live & (age > {16'd0, age_limit});
			end else if (take_nxt) begin
				drop_q <= nxt_drop;
			end
			if (ctl.compare) begin
				match_q <= live & (ident_q == unit_id);
			end
		end
	end

	assign ident     = ident_q;
	assign seen      = seen_q;
	assign drop      = drop_q;
	assign match     = match_q;
	assign shift_out = shift_here;

endmodule

>>> rtl/id_table_with_aging.sv
// Ordered table of unit ids with last-seen times, held in a row of cells.
// Pulse start while busy is low; the word on cmd is taken at that edge and
// busy stays high until the result. A learn compares the id in every cell
// in ST_LOOK, then in ST_UPDATE refreshes, appends or flags a full miss.
// An age sweep marks every live entry older than age_limit, then removes
// the marked entries; each removal closes its gap by shifting the cells
// above it down one place per cycle. The result word is valid on result
// while done is high, which is for a single cycle, and cannot be held
// off. Write age_limit through cfg_we/cfg_data only while the block is idle.
module id_table_with_aging #(
	parameter int TABLE_DEPTH = itab_pkg::TABLE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  itab_pkg::in_word_t  cmd,
	output logic                done,
	output itab_pkg::out_word_t result,
	input  logic                cfg_we,
	input  logic [15:0]         cfg_data
);

	localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	itab_pkg::state_t    state_q, state_nxt;
	itab_pkg::out_word_t res_q;
	itab_pkg::cell_ctl_t ctl_w [TABLE_DEPTH];

	logic          done_q;
	logic [15:0]   lim_q;
	logic          op_q;
	logic [31:0]   id_q;
	logic [31:0]   now_q;
	logic [CW-1:0] count_q;

	logic [31:0] ident_w [TABLE_DEPTH+1];
	logic [31:0] seen_w  [TABLE_DEPTH+1];
	logic [TABLE_DEPTH:0]   drop_w;
	logic [TABLE_DEPTH:0]   shf_w;
	logic [TABLE_DEPTH-1:0] match_w;

	logic          accept;
	logic          any_match;
	logic          any_drop;
	logic          room;
	logic [IW-1:0] hit_idx;
	logic [31:0]   slot_wide;
	logic [31:0]   cnt_wide;
	logic [CW-1:0] count_upd;

	logic look_en, mark_en, upd_en, shift_en, age_fin;

	assign accept    = start & (state_q == itab_pkg::ST_IDLE);
	assign any_match = |match_w;
	assign any_drop  = |drop_w[TABLE_DEPTH-1:0];
	assign room      = count_q < CW'(TABLE_DEPTH);

	assign ident_w[TABLE_DEPTH] = '0;
	assign seen_w[TABLE_DEPTH]  = '0;
	assign drop_w[TABLE_DEPTH]  = 1'b0;
	assign shf_w[0]             = 1'b0;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			itab_pkg::ST_IDLE: begin
				if (start) begin
					state_nxt = (cmd.opcode == itab_pkg::OP_AGE) ? itab_pkg::ST_MARK
					                                             : itab_pkg::ST_LOOK;
				end
			end
			itab_pkg::ST_LOOK:   state_nxt = itab_pkg::ST_UPDATE;
			itab_pkg::ST_UPDATE: state_nxt = itab_pkg::ST_IDLE;
			itab_pkg::ST_MARK:   state_nxt = itab_pkg::ST_SHIFT;
			itab_pkg::ST_SHIFT: begin
				if (!any_drop) begin
					state_nxt = itab_pkg::ST_IDLE;
				end
			end
			default: state_nxt = itab_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		look_en  = 1'b0;
		mark_en  = 1'b0;
		upd_en   = 1'b0;
		shift_en = 1'b0;
		age_fin  = 1'b0;
		unique case (state_q)
			itab_pkg::ST_IDLE:   ;
			itab_pkg::ST_LOOK:   look_en = 1'b1;
			itab_pkg::ST_UPDATE: upd_en = 1'b1;
			itab_pkg::ST_MARK:   mark_en = 1'b1;
			itab_pkg::ST_SHIFT: begin
				shift_en = any_drop;
				age_fin  = ~any_drop;
			end
			default: ;
		endcase
	end

	always_comb begin
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			ctl_w[i].compare    = look_en;
			ctl_w[i].mark       = mark_en;
			ctl_w[i].shift      = shift_en;
			ctl_w[i].write_id   = upd_en & ~any_match & room & (count_q == CW'(i));
			ctl_w[i].write_time = upd_en & (match_w[i] | (~any_match & room
			                      & (count_q == CW'(i))));
		end
	end

	// ids are unique in the table, so at most one match bit is set
	always_comb begin
		hit_idx = '0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			if (match_w[i]) begin
				hit_idx = hit_idx | IW'(i);
			end
		end
	end

	always_comb begin
		count_upd = count_q;
		slot_wide = 32'(TABLE_DEPTH - 1);
		if (any_match) begin
			slot_wide = 32'(hit_idx);
		end else if (room) begin
			slot_wide = 32'(count_q);
			count_upd = count_q + CW'(1);
		end
	end

	assign cnt_wide = upd_en ? 32'(count_upd) : 32'(count_q);

	genvar gi;
	generate
		for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
			itab_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctl       (ctl_w[gi]),
				.unit_id   (id_q),
				.now_time  (now_q),
				.age_limit (lim_q),
				.live      (CW'(gi) < count_q),
				.nxt_ident (ident_w[gi+1]),
				.nxt_seen  (seen_w[gi+1]),
				.nxt_drop  (drop_w[gi+1]),
				.shift_in  (shf_w[gi]),
				.ident     (ident_w[gi]),
				.seen      (seen_w[gi]),
				.drop      (drop_w[gi]),
				.match     (match_w[gi]),
				.shift_out (shf_w[gi+1])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= itab_pkg::ST_IDLE;
			count_q <= '0;
			lim_q   <= itab_pkg::AGE_LIMIT_RESET;
			done_q  <= 1'b0;
			op_q    <= itab_pkg::OP_LEARN;
		end else begin
			state_q <= state_nxt;
			done_q  <= upd_en | age_fin;
			if (cfg_we) begin
				lim_q <= cfg_data;
			end
			if (accept) begin
				op_q <= cmd.opcode;
			end
			if (upd_en) begin
				count_q <= count_upd;
			end else if (shift_en) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			id_q  <= cmd.unit_id;
			now_q <= cmd.now_time;
		end
		if (upd_en) begin
			res_q.slot_index <= slot_wide[3:0];
			res_q.was_hit    <= any_match;
			res_q.full_miss  <= ~any_match & ~room;
			res_q.live_count <= cnt_wide[4:0];
		end else if (age_fin) begin
			res_q.slot_index <= '0;
			res_q.was_hit    <= 1'b0;
			res_q.full_miss  <= 1'b0;
			res_q.live_count <= cnt_wide[4:0];
		end
	end

	assign busy   = (state_q != itab_pkg::ST_IDLE);
	assign done   = done_q;
	assign result = res_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_DEPTH))
		else $error("entry count beyond table depth");

	a_single_hit: assert property (@(posedge clk) disable iff (!arst_n)
		upd_en |-> $onehot0(match_w))
		else $error("more than one cell matched");

	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(done) |-> $past(state_q == itab_pkg::ST_UPDATE || state_q == itab_pkg::ST_SHIFT))
		else $error("result word without finished item");

	a_age_word: assert property (@(posedge clk) disable iff (!arst_n)
		(done && op_q == itab_pkg::OP_AGE) |-> (result.slot_index == '0 && !result.was_hit
		&& !result.full_miss))
		else $error("age sweep word carries learn flags");

	a_full_no_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.full_miss) |-> !result.was_hit)
		else $error("full miss and hit together");

endmodule
